FILE: rtl/core/encspd_pkg.sv
// ----------------------------------------------------------------------------
// encspd_pkg
// Shared types and constants of the encoder speed moving average block.
// ----------------------------------------------------------------------------
package encspd_pkg;

    // field and datapath widths
    localparam int POS_W  = 32;
    localparam int CPR_W  = 16;
    localparam int SCALE_W = 24;
    localparam int NUM_W  = POS_W + SCALE_W;
    localparam int DEN_W  = CPR_W + POS_W;
    localparam int QUO_W  = 32;
    localparam int CNT_W  = 6;

    // ring depth, a power of two so the averages are a plain shift
    localparam int DEPTH  = 8;
    localparam int AVG_SH = $clog2(DEPTH);

    // rpm scale: 60 s / 100 us, times 16 for the fraction bits
    localparam logic [SCALE_W-1:0] RPM_SCALE = 24'd9600000;
    localparam logic [CPR_W-1:0]   CPR_RESET = 16'd1024;
    localparam logic [QUO_W-1:0]   RPM_MAX   = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0]   RPM_MIN   = 32'h8000_0000;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MULT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PUSH,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic latch_first;
        logic sample;
        logic mult;
        logic div_start;
        logic take_rpm;
        logic push;
        logic load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic have_last;
        logic tick_same;
        logic spd_done;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/encspd_div.sv
// ----------------------------------------------------------------------------
// encspd_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Flags overflow at start when the quotient would not fit in 32 bits.
// ----------------------------------------------------------------------------
module encspd_div
    import encspd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf,
    output logic             o_done
);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_shf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             start_ovf;

    // one restoring step
    assign trial     = {r_rem, r_shf[QUO_W-1]};
    assign diff      = trial - {1'b0, r_den};
    assign ge        = trial >= {1'b0, r_den};
    assign start_ovf = DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den;

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= start_ovf ? CNT_W'(0) : CNT_W'(QUO_W);
            r_done <= start_ovf;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_shf <= i_num[QUO_W-1:0];
            r_ovf <= start_ovf;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_shf <= {r_shf[QUO_W-2:0], ge};
        end
    end

    assign o_quo  = r_shf;
    assign o_ovf  = r_ovf;
    assign o_done = r_done;

endmodule

FILE: rtl/core/encspd_dp.sv
// ----------------------------------------------------------------------------
// encspd_dp
// Datapath: deltas, speed scaling and division, sample ring with running
// sums, averages and the output register.
// ----------------------------------------------------------------------------
module encspd_dp
    import encspd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CPR_W-1:0]        i_cfg_wdata,
    input  logic signed [POS_W-1:0] i_encoder_position,
    input  logic [POS_W-1:0]        i_tick_count,
    input  logic                    i_stall,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_valid,
    output logic                    o_valid_res,
    output logic signed [POS_W-1:0] o_raw_rpm,
    output logic signed [POS_W-1:0] o_avg_rpm,
    output logic [POS_W-1:0]        o_raw_tick_delta,
    output logic [POS_W-1:0]        o_avg_tick_delta
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = POS_W + $clog2(DEPTH);

    // configuration and input latches
    logic [CPR_W-1:0] r_cpr;
    logic [POS_W-1:0] r_pos_in;
    logic [POS_W-1:0] r_tick_in;
    logic [POS_W-1:0] r_last_pos;
    logic [POS_W-1:0] r_last_tick;
    logic             r_have_last;

    // sample computation
    logic             r_neg;
    logic [POS_W-1:0] r_mag;
    logic [POS_W-1:0] r_dt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [POS_W-1:0] r_rpm;

    // ring and sums
    logic [POS_W-1:0]  r_spd_mem [DEPTH];
    logic [POS_W-1:0]  r_gap_mem [DEPTH];
    logic [POS_W-1:0]  r_old_spd;
    logic [POS_W-1:0]  r_old_gap;
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_spd_sum;
    logic [POS_W-1:0]  r_gap_sum;
    logic [POS_W-1:0]  r_raw_rpm;
    logic [POS_W-1:0]  r_raw_gap;

    // output register
    logic             r_out_valid;
    logic             r_o_valid_res;
    logic [POS_W-1:0] r_o_raw_rpm;
    logic [POS_W-1:0] r_o_avg_rpm;
    logic [POS_W-1:0] r_o_raw_gap;
    logic [POS_W-1:0] r_o_avg_gap;

    // combinational helpers
    logic [CPR_W-1:0] cpr_eff;
    logic [POS_W-1:0] pos_diff;
    logic [POS_W-1:0] tick_diff;
    logic             full;
    logic [SUM_W-1:0] spd_mag;
    logic [SUM_W-1:0] spd_avg_mag;
    logic [POS_W-1:0] avg_rpm;
    logic [POS_W-1:0] avg_gap;
    logic [QUO_W-1:0] div1_quo;
    logic             div1_ovf;
    logic             div1_done;
    logic [POS_W-1:0] rpm_sat;
    logic [SUM_W-1:0] old_spd_ext;
    logic [SUM_W-1:0] new_spd_ext;
    logic [SUM_W-1:0] spd_sum_upd;
    logic [POS_W-1:0] gap_sum_upd;

    assign cpr_eff   = (r_cpr == '0) ? CPR_W'(1) : r_cpr;
    assign pos_diff  = r_pos_in - r_last_pos;
    assign tick_diff = r_tick_in - r_last_tick;
    assign full      = (r_fill == FILL_W'(DEPTH));
    assign spd_mag   = r_spd_sum[SUM_W-1] ? (SUM_W'(0) - r_spd_sum) : r_spd_sum;

    // averages: magnitude shifted down, sign put back, truncation toward zero
    assign spd_avg_mag = spd_mag >> AVG_SH;
    assign avg_rpm     = r_spd_sum[SUM_W-1] ? (POS_W'(0) - spd_avg_mag[POS_W-1:0])
                                            : spd_avg_mag[POS_W-1:0];
    assign avg_gap     = r_gap_sum >> AVG_SH;

    // speed quotient divider
    encspd_div u_div_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quo   (div1_quo),
        .o_ovf   (div1_ovf),
        .o_done  (div1_done)
    );

    // signed saturation of the speed quotient
    always_comb begin
        if (r_neg) begin
            rpm_sat = (div1_ovf || div1_quo[QUO_W-1]) ? RPM_MIN : (QUO_W'(0) - div1_quo);
        end else begin
            rpm_sat = (div1_ovf || div1_quo[QUO_W-1]) ? RPM_MAX : div1_quo;
        end
    end

    // running sum updates, oldest entry leaves only once the ring is full
    assign old_spd_ext = full ? {{(SUM_W-POS_W){r_old_spd[POS_W-1]}}, r_old_spd} : '0;
    assign new_spd_ext = {{(SUM_W-POS_W){r_rpm[POS_W-1]}}, r_rpm};
    assign spd_sum_upd = r_spd_sum - old_spd_ext + new_spd_ext;
    assign gap_sum_upd = r_gap_sum - (full ? r_old_gap : '0) + r_dt;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr <= CPR_RESET;
        end else if (i_cfg_we) begin
            r_cpr <= i_cfg_wdata;
        end
    end

    // input latch and last position/tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos  <= '0;
            r_last_tick <= '0;
            r_have_last <= 1'b0;
        end else if (i_cmd.latch_first || i_cmd.sample) begin
            r_last_pos  <= r_pos_in;
            r_last_tick <= r_tick_in;
            r_have_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pos_in  <= $unsigned(i_encoder_position);
            r_tick_in <= i_tick_count;
        end
    end

    // deltas, scaling products and saturated speed
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_neg <= pos_diff[POS_W-1];
            r_mag <= pos_diff[POS_W-1] ? (POS_W'(0) - pos_diff) : pos_diff;
            r_dt  <= tick_diff;
        end
        if (i_cmd.mult) begin
            r_num <= NUM_W'(r_mag) * NUM_W'(RPM_SCALE);
            r_den <= DEN_W'(cpr_eff) * DEN_W'(r_dt);
        end
        if (i_cmd.take_rpm) begin
            r_rpm <= rpm_sat;
        end
    end

    // sample ring memory, read of the oldest slot ahead of the push
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_old_spd <= r_spd_mem[r_slot];
            r_old_gap <= r_gap_mem[r_slot];
        end
        if (i_cmd.push) begin
            r_spd_mem[r_slot] <= r_rpm;
            r_gap_mem[r_slot] <= r_dt;
        end
    end

    // ring pointer, fill level and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_fill    <= '0;
            r_spd_sum <= '0;
            r_gap_sum <= '0;
        end else if (i_cmd.push) begin
            r_slot    <= (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
            r_fill    <= full ? r_fill : r_fill + FILL_W'(1);
            r_spd_sum <= spd_sum_upd;
            r_gap_sum <= gap_sum_upd;
        end
    end

    // newest sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_raw_rpm <= r_rpm;
            r_raw_gap <= r_dt;
        end
    end

    // output register, freed by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_valid_res <= full;
            r_o_raw_rpm   <= full ? r_raw_rpm : '0;
            r_o_avg_rpm   <= full ? avg_rpm : '0;
            r_o_raw_gap   <= full ? r_raw_gap : '0;
            r_o_avg_gap   <= full ? avg_gap : '0;
        end
    end

    // status to the controller
    assign o_sts.have_last = r_have_last;
    assign o_sts.tick_same = (r_tick_in == r_last_tick);
    assign o_sts.spd_done  = div1_done;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid          = r_out_valid;
    assign o_valid_res      = r_o_valid_res;
    assign o_raw_rpm        = $signed(r_o_raw_rpm);
    assign o_avg_rpm        = $signed(r_o_avg_rpm);
    assign o_raw_tick_delta = r_o_raw_gap;
    assign o_avg_tick_delta = r_o_avg_gap;

endmodule

FILE: rtl/core/encspd_ctrl.sv
// ----------------------------------------------------------------------------
// encspd_ctrl
// Controller: sequences one query through check, scaling, division, ring
// push and output.
// ----------------------------------------------------------------------------
module encspd_ctrl
    import encspd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.have_last || i_sts.tick_same) n_state = S_OUT;
                else n_state = S_MULT;
            end
            S_MULT:     n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_sts.spd_done) n_state = S_PUSH;
            end
            S_PUSH:     n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load_in = i_valid;
            end
            S_CHECK: begin
                o_cmd.latch_first = !i_sts.have_last;
                o_cmd.sample      = i_sts.have_last && !i_sts.tick_same;
            end
            S_MULT:     o_cmd.mult = 1'b1;
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_DIV_WAIT: o_cmd.take_rpm = i_sts.spd_done;
            S_PUSH:     o_cmd.push = 1'b1;
            S_OUT:      o_cmd.load_out = i_sts.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/encoder_speed_moving_average.sv
// ----------------------------------------------------------------------------
// encoder_speed_moving_average
// A query without a new sample goes from the check straight to the output
// load; a new sample first passes scaling, the 32-step bit-serial speed
// divider and the ring push, and the divider skips its steps when the speed
// saturates at divider start. One query at a time: the next is taken in the
// cycle after the result is loaded, and an output stall holds that load back.
// Synchronous active-low reset; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module encoder_speed_moving_average
    import encspd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CPR_W-1:0]        i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_encoder_position,
    input  logic [POS_W-1:0]        i_tick_count,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_valid_res,
    output logic signed [POS_W-1:0] o_raw_rpm,
    output logic signed [POS_W-1:0] o_avg_rpm,
    output logic [POS_W-1:0]        o_raw_tick_delta,
    output logic [POS_W-1:0]        o_avg_tick_delta
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    encspd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic, ring and output register
    encspd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_encoder_position (i_encoder_position),
        .i_tick_count       (i_tick_count),
        .i_stall            (i_stall),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_valid            (o_valid),
        .o_valid_res        (o_valid_res),
        .o_raw_rpm          (o_raw_rpm),
        .o_avg_rpm          (o_avg_rpm),
        .o_raw_tick_delta   (o_raw_tick_delta),
        .o_avg_tick_delta   (o_avg_tick_delta)
    );

endmodule

FILE: sim/encoder_speed_moving_average_tb.sv
// ----------------------------------------------------------------------------
// encoder_speed_moving_average_tb
// Self-checking bench for the encoder speed moving average. A queue of speed
// queries feeds a clocked driver, a clocked monitor checks every result
// against an in-bench speed and ring-average predictor, and both sides idle
// at random. The run steps through several counts-per-revolution settings.
// ----------------------------------------------------------------------------
module encoder_speed_moving_average_tb;
    import encspd_pkg::*;

    localparam int RING_DEPTH  = DEPTH;
    localparam int PHASE_ITEMS = 222;
    localparam int IDLE_PAUSE  = 100;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] tick;
    } t_query;

    typedef struct {
        logic                    valid_res;
        logic signed [POS_W-1:0] raw_rpm;
        logic signed [POS_W-1:0] avg_rpm;
        logic [POS_W-1:0]        raw_tick_delta;
        logic [POS_W-1:0]        avg_tick_delta;
    } t_speed_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CPR_W-1:0]        i_cfg_wdata = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [POS_W-1:0] i_encoder_position = '0;
    logic [POS_W-1:0]        i_tick_count = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_valid_res;
    logic signed [POS_W-1:0] o_raw_rpm;
    logic signed [POS_W-1:0] o_avg_rpm;
    logic [POS_W-1:0]        o_raw_tick_delta;
    logic [POS_W-1:0]        o_avg_tick_delta;

    // pending queries and the reports they should produce
    t_query        query_q[$];
    t_speed_report report_q[$];

    // predictor state
    logic [CPR_W-1:0]        cpr_setting = CPR_RESET;
    logic signed [POS_W-1:0] speed_ring[RING_DEPTH];
    logic [POS_W-1:0]        gap_ring[RING_DEPTH];
    int                      ring_slot = 0;
    int                      ring_fill = 0;
    logic [POS_W-1:0]        held_position = '0;
    logic [POS_W-1:0]        held_tick = '0;
    bit                      seen_first = 1'b0;
    longint                  speed_sum = 0;
    logic [POS_W-1:0]        gap_sum = '0;

    // stimulus trajectory
    logic [POS_W-1:0] traj_position = '0;
    logic [POS_W-1:0] traj_tick = '0;

    // handshake bookkeeping
    t_query held_query;
    bit     tx_busy = 1'b0;
    int     tx_gap = 0;
    bit     tx_quiet = 1'b0;
    int     rx_wait = 0;
    bit     rx_quiet = 1'b0;
    int     idle_cycles = 0;
    int     n_mismatch = 0;

    encoder_speed_moving_average i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_encoder_position(i_encoder_position),
        .i_tick_count      (i_tick_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_valid_res       (o_valid_res),
        .o_raw_rpm         (o_raw_rpm),
        .o_avg_rpm         (o_avg_rpm),
        .o_raw_tick_delta  (o_raw_tick_delta),
        .o_avg_tick_delta  (o_avg_tick_delta)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // speed in rpm q.4, exact quotient truncated toward zero, then saturated
    function automatic logic signed [POS_W-1:0] rpm_of(input logic signed [POS_W-1:0] dpos,
                                                        input logic [POS_W-1:0] dtick);
        logic [CPR_W-1:0] cpr_eff;
        logic [63:0]      den;
        logic [63:0]      mag;
        logic [63:0]      quo;
        cpr_eff = (cpr_setting == '0) ? CPR_W'(1) : cpr_setting;
        den = 64'(cpr_eff) * 64'(dtick);
        mag = (dpos < 0) ? 64'(-longint'(dpos)) : 64'(dpos);
        quo = (mag * 64'(RPM_SCALE)) / den;
        if (dpos < 0) begin
            return (quo >= 64'h8000_0000) ? RPM_MIN : -quo[31:0];
        end
        return (quo > 64'h7FFF_FFFF) ? RPM_MAX : quo[31:0];
    endfunction

    // update the ring for one query and queue the report it should produce
    function automatic void predict_report(input t_query q);
        t_speed_report rep;
        logic [POS_W-1:0] dpos;
        logic [POS_W-1:0] dtick;
        logic signed [POS_W-1:0] rpm;
        int newest;
        if (!seen_first) begin
            held_position = q.position;
            held_tick = q.tick;
            seen_first = 1'b1;
        end else if (q.tick != held_tick) begin
            dpos = q.position - held_position;
            dtick = q.tick - held_tick;
            held_position = q.position;
            held_tick = q.tick;
            rpm = rpm_of($signed(dpos), dtick);
            // oldest entry leaves the sums once the ring is full
            if (ring_fill == RING_DEPTH) begin
                speed_sum -= speed_ring[ring_slot];
                gap_sum -= gap_ring[ring_slot];
            end else begin
                ring_fill++;
            end
            speed_ring[ring_slot] = rpm;
            gap_ring[ring_slot] = dtick;
            speed_sum += rpm;
            gap_sum += dtick;
            ring_slot = (ring_slot + 1) % RING_DEPTH;
        end
        rep = '{default: '0};
        if (ring_fill == RING_DEPTH) begin
            newest = (ring_slot + RING_DEPTH - 1) % RING_DEPTH;
            rep.valid_res = 1'b1;
            rep.raw_rpm = speed_ring[newest];
            rep.avg_rpm = 32'(speed_sum / RING_DEPTH);
            rep.raw_tick_delta = gap_ring[newest];
            rep.avg_tick_delta = gap_sum / 32'(RING_DEPTH);
        end
        report_q.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input logic [POS_W-1:0] expv,
                                        input logic [POS_W-1:0] actv);
        if (expv !== actv) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, expv, actv);
            n_mismatch++;
        end
    endfunction

    // wait per transfer, with quiet stretches of back-to-back traffic
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 29) == 0) begin
            quiet = !quiet;
        end
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // queue a query relative to the trajectory; a repeated tick leaves it alone
    task automatic push_step(input logic [POS_W-1:0] dpos, input logic [POS_W-1:0] dtick);
        t_query q;
        q.position = traj_position + dpos;
        q.tick = traj_tick + dtick;
        if (dtick != '0) begin
            traj_position = q.position;
            traj_tick = q.tick;
        end
        query_q.push_back(q);
    endtask

    // random queries: mostly motion with random speed, some repeats and noise
    task automatic push_random(input int count);
        int kind;
        logic [POS_W-1:0] dtick;
        logic [POS_W-1:0] mag;
        t_query q;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                q.position = $urandom;
                q.tick = $urandom;
                traj_position = q.position;
                traj_tick = q.tick;
                query_q.push_back(q);
            end else if (kind < 13) begin
                push_step($urandom, '0);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        dtick = $urandom_range(1, 4);
                    end
                    1: begin
                        dtick = $urandom_range(1, 1000);
                    end
                    2: begin
                        dtick = $urandom_range(1, 100000);
                    end
                    default: begin
                        dtick = $urandom;
                    end
                endcase
                case ($urandom_range(0, 4))
                    0: begin
                        mag = $urandom_range(0, 16);
                    end
                    1: begin
                        mag = $urandom_range(0, 5000);
                    end
                    2: begin
                        mag = dtick * $urandom_range(0, 3000);
                    end
                    3: begin
                        mag = $urandom_range(0, 32'h00FF_FFFF);
                    end
                    default: begin
                        mag = $urandom;
                    end
                endcase
                push_step($urandom_range(0, 1) ? -mag : mag, dtick);
            end
        end
    endtask

    // wait until every query has its report, then let the block settle
    task automatic drain();
        while (query_q.size() != 0 || tx_busy || report_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_counts_per_rev(input logic [CPR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cpr_setting = value;
    endtask

    // query driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_report(held_query);
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (query_q.size() != 0) begin
                    held_query = query_q.pop_front();
                    i_encoder_position <= held_query.position;
                    i_tick_count <= held_query.tick;
                    tx_busy = 1'b1;
                    tx_gap = draw_wait(tx_quiet);
                end
            end
            i_valid <= tx_busy;
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        t_speed_report rep;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (report_q.size() == 0) begin
                    $display("%0t unexpected report: expected none actual %h %h %h %h %h", $time,
                             o_valid_res, o_raw_rpm, o_avg_rpm, o_raw_tick_delta,
                             o_avg_tick_delta);
                    n_mismatch++;
                end else begin
                    rep = report_q.pop_front();
                    check_field("valid_res", 32'(rep.valid_res), 32'(o_valid_res));
                    check_field("raw_rpm", rep.raw_rpm, o_raw_rpm);
                    check_field("avg_rpm", rep.avg_rpm, o_avg_rpm);
                    check_field("raw_tick_delta", rep.raw_tick_delta, o_raw_tick_delta);
                    check_field("avg_tick_delta", rep.avg_tick_delta, o_avg_tick_delta);
                end
                rx_wait = draw_wait(rx_quiet);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_stall <= (rx_wait != 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // reset, directed queries, then random phases over several settings
    initial begin
        logic [CPR_W-1:0] settings[8];
        settings = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(2, 65534)), 16'd360,
                     16'($urandom_range(2, 65534)), 16'($urandom_range(2, 400)), 16'd1024};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting; first query only latches, then a repeated tick
        traj_position = 32'h7FFF_FFF0;
        traj_tick = 32'hFFFF_FFF0;
        push_step('0, '0);
        push_step(32'h0012_3456, '0);
        // both counters wrap
        push_step(32'd32, 32'd21);
        push_step('0, 32'd1);
        push_step(-32'd1, 32'd1);
        // saturation both ways, widest tick gap
        push_step(32'h7FFF_FFFF, 32'd1);
        push_step(32'h8000_0000, 32'd1);
        push_step(32'd1000, 32'hFFFF_FFFF);
        push_step(32'd1, 32'd1);
        push_step(-32'd1, 32'd1);
        // ring now full: repeat tick reports current contents
        push_step(32'd5, '0);
        push_step(-32'd3, 32'd7);
        push_step(32'hFFF0_0000, 32'd2);
        push_step(32'd123456, 32'd100);
        push_step(-32'd77, 32'd3);
        push_step('0, 32'h8000_0000);
        push_step(32'd40, 32'd40);
        push_step(-32'd1, 32'h0000_FFFF);
        push_step(32'd7, '0);
        push_step(32'd2, 32'd5);
        drain();

        foreach (settings[p]) begin
            write_counts_per_rev(settings[p]);
            push_random(PHASE_ITEMS);
            drain();
        end

        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
